// ===== src/lfic_pkg.sv =====
// Shared types and constants for the line follower intersection controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lfic_pkg;

    localparam int SENSOR_W            = 12;
    localparam int SAMPLE_BITS_DEFAULT = 12;
    localparam int SAMPLE_BITS_MAX     = 16;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 12;
    localparam int VEL_W               = 16;
    localparam int CALC_W              = 20;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SPEED     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER_GAIN     = 2'd2;

    localparam logic [11:0] LINE_THRESHOLD_RESET = 12'd300;
    localparam logic [11:0] BASE_SPEED_RESET     = 12'd1024;
    localparam logic [9:0]  INNER_GAIN_RESET     = 10'd282;

    typedef enum logic [2:0] {
        MODE_FOLLOW  = 3'd0,
        MODE_BLANK   = 3'd1,
        MODE_WAIT_L  = 3'd2,
        MODE_TURN_L  = 3'd3,
        MODE_WAIT_R  = 3'd4,
        MODE_TURN_R  = 3'd5
    } mode_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_CALC
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_0;
        logic [SENSOR_W-1:0] sensor_1;
        logic [SENSOR_W-1:0] sensor_2;
        logic [SENSOR_W-1:0] sensor_3;
        logic [SENSOR_W-1:0] sensor_4;
        logic [SENSOR_W-1:0] sensor_5;
        logic [SENSOR_W-1:0] sensor_6;
        logic [SENSOR_W-1:0] sensor_7;
    } sensor_item_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] left_velocity;
        logic signed [VEL_W-1:0] right_velocity;
        logic [2:0]              next_mode;
        logic signed [3:0]       line_position;
        logic [7:0]              sensor_pattern;
    } result_item_t;

    function automatic logic signed [VEL_W-1:0] sat16(input logic signed [CALC_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v > CALC_W'(32767))
            r = 16'sh7FFF;
        else if (v < -CALC_W'(32768))
            r = 16'sh8000;
        else
            r = v[VEL_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lfic_ctrl.sv =====
// Sequencer for the controller: capture an item, then commit its result.
// Depends on lfic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfic_ctrl
    import lfic_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     sensor_valid,
    output logic          sensor_ready,
    output logic          result_valid,
    input  wire logic     result_ready,
    output ctl_cmd_t      cmd
);

    ctl_state_t state_reg, state_next;
    logic       valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        sensor_ready = 1'b0;
        cmd          = '0;
        if (valid_reg && result_ready)
            valid_next = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                sensor_ready = 1'b1;
                if (sensor_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = CTL_CALC;
                end
            end
            CTL_CALC:
            begin
                // hold until the output register is free or being drained
                if (!valid_reg || result_ready)
                begin
                    cmd.commit = 1'b1;
                    valid_next = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    assign result_valid = valid_reg;

endmodule

`default_nettype wire

// ===== src/lfic_datapath.sv =====
// Datapath: thresholding, position encoder, mode update, wheel velocities,
// configuration registers and the result register. Depends on lfic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfic_datapath
    import lfic_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ctl_cmd_t               cmd,
    input  wire sensor_item_t           sensors,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output result_item_t                result
);

    localparam logic [SAMPLE_BITS_MAX-1:0] SAMPLE_MASK =
        SAMPLE_BITS_MAX'((33'd1 << SAMPLE_BITS) - 33'd1);

    logic [11:0]  threshold_reg;
    logic [11:0]  base_reg;
    logic [9:0]   gain_reg;
    mode_t        mode_reg, mode_next;
    logic [7:0]   prev_reg;
    logic signed [3:0] held_reg, held_next;
    logic [7:0]   pattern_reg;
    result_item_t result_reg;

    logic [SENSOR_W-1:0] samples [8];
    logic [7:0]          pattern_next;
    logic signed [3:0]   weight;
    mode_t               check_mode;
    logic signed [14:0]  wg;
    logic signed [CALC_W-1:0] bx, gx, wx, wgx, t, t7, lv, rv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= LINE_THRESHOLD_RESET;
            base_reg      <= BASE_SPEED_RESET;
            gain_reg      <= INNER_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_THRESHOLD: threshold_reg <= cfg_data;
                CFG_BASE_SPEED:     base_reg      <= cfg_data;
                CFG_INNER_GAIN:     gain_reg      <= cfg_data[9:0];
                default:            ;
            endcase
        end
    end

    // Threshold: sensor 0 lands in the most significant bit
    assign samples[0] = sensors.sensor_0;
    assign samples[1] = sensors.sensor_1;
    assign samples[2] = sensors.sensor_2;
    assign samples[3] = sensors.sensor_3;
    assign samples[4] = sensors.sensor_4;
    assign samples[5] = sensors.sensor_5;
    assign samples[6] = sensors.sensor_6;
    assign samples[7] = sensors.sensor_7;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            pattern_next[7 - i] =
                ((SAMPLE_BITS_MAX'(samples[i]) & SAMPLE_MASK) <
                 SAMPLE_BITS_MAX'(threshold_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            pattern_reg <= pattern_next;
    end

    // Priority encoder: centre pair first, then outermost sensors inwards
    always_comb
    begin
        if (pattern_reg[4] && pattern_reg[3])
            weight = 4'sd0;
        else if (pattern_reg[7])
            weight = -4'sd6;
        else if (pattern_reg[0])
            weight = 4'sd6;
        else if (pattern_reg[6])
            weight = -4'sd4;
        else if (pattern_reg[1])
            weight = 4'sd4;
        else if (pattern_reg[5])
            weight = -4'sd3;
        else if (pattern_reg[2])
            weight = 4'sd3;
        else if (pattern_reg[4])
            weight = -4'sd2;
        else if (pattern_reg[3])
            weight = 4'sd2;
        else
            weight = held_reg;
    end

    // Intersection check on the previous and current patterns
    always_comb
    begin
        if ((prev_reg == 8'h10 || prev_reg == 8'h08) && pattern_reg == 8'h00)
            check_mode = MODE_BLANK;
        else if ((prev_reg == 8'hF0 || prev_reg == 8'hF8) &&
                 (pattern_reg inside {8'h90, 8'hD0, 8'h98, 8'hC8, 8'hD8, 8'hE8}))
            check_mode = MODE_WAIT_L;
        else if ((prev_reg == 8'h0F || prev_reg == 8'h1F) &&
                 (pattern_reg inside {8'h09, 8'h0B, 8'h19, 8'h13, 8'h1B, 8'h17}))
            check_mode = MODE_WAIT_R;
        else
            check_mode = MODE_FOLLOW;
    end

    assign bx  = $signed({8'd0, base_reg});
    assign gx  = $signed({10'd0, gain_reg});
    assign wx  = CALC_W'(weight);
    assign wg  = weight * $signed({1'b0, gain_reg});
    assign wgx = CALC_W'(wg);

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        t         = '0;
        t7        = '0;
        lv        = (bx <<< 3) + (bx <<< 1);
        rv        = (bx <<< 3) + (bx <<< 1);
        case (mode_reg)
            MODE_BLANK:
            begin
                held_next = 4'sd0;
                mode_next = check_mode;
            end
            MODE_WAIT_L:
            begin
                if (pattern_reg inside {8'h3C, 8'h7E, 8'hFF})
                    mode_next = MODE_TURN_L;
            end
            MODE_WAIT_R:
            begin
                if (pattern_reg inside {8'h3C, 8'h7E, 8'hFF})
                    mode_next = MODE_TURN_R;
            end
            MODE_TURN_L:
            begin
                t  = bx - (gx <<< 1) - gx;
                lv = (t <<< 3) - t;
                rv = (bx + CALC_W'(768)) <<< 3;
                if (pattern_reg inside {8'h80, 8'h10, 8'h20, 8'h30})
                    mode_next = MODE_FOLLOW;
            end
            MODE_TURN_R:
            begin
                t  = bx - CALC_W'(768);
                lv = (bx + (gx <<< 1) + gx) <<< 3;
                rv = (t <<< 3) - t;
                if (pattern_reg inside {8'h01, 8'h08, 8'h04, 8'h0C})
                    mode_next = MODE_FOLLOW;
            end
            default:
            begin
                held_next = weight;
                mode_next = check_mode;
                if (weight > 4'sd0)
                begin
                    t  = (bx <<< 1) - wgx;
                    t7 = (t <<< 3) - t;
                    lv = (bx + (wx <<< 7)) <<< 3;
                    rv = (t7 + CALC_W'(1)) >>> 1;
                end
                else if (weight < 4'sd0)
                begin
                    t  = (bx <<< 1) + wgx;
                    t7 = (t <<< 3) - t;
                    lv = (t7 + CALC_W'(1)) >>> 1;
                    rv = (bx - (wx <<< 7)) <<< 3;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FOLLOW;
            prev_reg <= 8'd0;
            held_reg <= 4'sd0;
        end
        else if (cmd.commit)
        begin
            mode_reg <= mode_next;
            prev_reg <= pattern_reg;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg.left_velocity  <= sat16(lv);
            result_reg.right_velocity <= sat16(rv);
            result_reg.next_mode      <= mode_next;
            result_reg.line_position  <= held_next;
            result_reg.sensor_pattern <= pattern_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/line_follower_intersection_controller.sv =====
// Line follower with intersection handling: eight ground-sensor samples in per tick,
// two wheel velocities, the new mode, the line position and the sensor pattern out.
//
// Channels: sensors/sensor_valid/sensor_ready carries one scan per item;
// result/result_valid/result_ready carries one result item per scan.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 line_threshold,
// 1 base_speed, 2 inner_gain); other indexes are ignored. Write only while idle.
// Timing: an item is taken in a capture cycle that thresholds the samples; a compute
// cycle then runs the encoder, mode update and velocity arithmetic and loads the
// result into the output register, raising result_valid. No new item is taken
// until the compute step has committed its result.
// A stalled receiver holds the result register; the next item may still be
// captured, and its compute step waits until the held result is taken.
// Reset puts the block in follow mode with a cleared pattern history, a centred
// position and the default register values; no result is pending.
// Depends on lfic_pkg, lfic_ctrl and lfic_datapath.
`timescale 1ns / 1ps
`default_nettype none

module line_follower_intersection_controller
    import lfic_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sensor_valid,
    output logic                        sensor_ready,
    input  wire sensor_item_t           sensors,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_item_t                result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    ctl_cmd_t cmd;

    lfic_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sensor_valid (sensor_valid),
        .sensor_ready (sensor_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    lfic_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sensors   (sensors),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== bench/tb_line_follower_intersection_controller.sv =====
// Self-checking testbench for line_follower_intersection_controller.
// Drives sensor scans with random gaps and stalls and predicts each result item.
// Depends on lfic_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb_line_follower_intersection_controller;
    import lfic_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam logic [5:0][7:0] LEFT_CUR_CODES   = {8'h90, 8'hD0, 8'h98, 8'hC8, 8'hD8, 8'hE8};
    localparam logic [5:0][7:0] RIGHT_CUR_CODES  = {8'h09, 8'h0B, 8'h19, 8'h13, 8'h1B, 8'h17};
    localparam logic [5:0][7:0] ENTER_CODES      = {8'h3C, 8'h7E, 8'hFF, 8'h3C, 8'h7E, 8'hFF};
    localparam logic [5:0][7:0] LEFT_EXIT_CODES  = {8'h80, 8'h10, 8'h20, 8'h30, 8'h80, 8'h10};
    localparam logic [5:0][7:0] RIGHT_EXIT_CODES = {8'h01, 8'h08, 8'h04, 8'h0C, 8'h01, 8'h08};

    logic                   clk;
    logic                   rst_n;
    logic                   sensor_valid = 1'b0;
    logic                   sensor_ready;
    sensor_item_t           sensors      = '0;
    logic                   result_valid;
    logic                   result_ready;
    result_item_t           result;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // Predicted controller state and registers
    logic [11:0]       line_threshold = LINE_THRESHOLD_RESET;
    logic [11:0]       base_speed     = BASE_SPEED_RESET;
    logic [9:0]        inner_gain     = INNER_GAIN_RESET;
    mode_t             cur_mode       = MODE_FOLLOW;
    logic [7:0]        prev_pattern   = 8'h00;
    logic signed [3:0] held_position  = 4'sd0;

    result_item_t pending_commands[$];
    result_item_t expected_cmd;

    bit idle_on           = 1'b1;
    int ready_hold_cycles = 0;
    int items_sent        = 0;
    int fail_count        = 0;
    int cycle_count       = 0;

    line_follower_intersection_controller u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sensor_valid (sensor_valid),
        .sensor_ready (sensor_ready),
        .sensors      (sensors),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_line_follower_intersection_controller failed");
            $finish;
        end
    end

    function automatic bit in_codes(logic [7:0] pat, logic [5:0][7:0] codes);
        for (int i = 0; i < 6; i++)
            if (codes[i] == pat)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_code(logic [5:0][7:0] codes);
        return codes[$urandom_range(0, 5)];
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Centre pair wins, then outermost sensors inwards, otherwise hold
    function automatic logic signed [3:0] line_weight(logic [7:0] pat, logic signed [3:0] hold);
        if (pat[4] && pat[3])
            return 4'sd0;
        if (pat[7])
            return -4'sd6;
        if (pat[0])
            return 4'sd6;
        if (pat[6])
            return -4'sd4;
        if (pat[1])
            return 4'sd4;
        if (pat[5])
            return -4'sd3;
        if (pat[2])
            return 4'sd3;
        if (pat[4])
            return -4'sd2;
        if (pat[3])
            return 4'sd2;
        return hold;
    endfunction

    function automatic mode_t intersection_mode(logic [7:0] prev, logic [7:0] pat);
        if ((prev == 8'h10 || prev == 8'h08) && pat == 8'h00)
            return MODE_BLANK;
        if ((prev == 8'hF0 || prev == 8'hF8) && in_codes(pat, LEFT_CUR_CODES))
            return MODE_WAIT_L;
        if ((prev == 8'h0F || prev == 8'h1F) && in_codes(pat, RIGHT_CUR_CODES))
            return MODE_WAIT_R;
        return MODE_FOLLOW;
    endfunction

    task automatic compute_wheel_command(input sensor_item_t scan);
        logic [7:0]   pat;
        logic [7:0]   prev;
        longint       b;
        longint       g;
        longint       w;
        longint       lv;
        longint       rv;
        result_item_t cmd;
        pat = {scan.sensor_0 < line_threshold, scan.sensor_1 < line_threshold,
               scan.sensor_2 < line_threshold, scan.sensor_3 < line_threshold,
               scan.sensor_4 < line_threshold, scan.sensor_5 < line_threshold,
               scan.sensor_6 < line_threshold, scan.sensor_7 < line_threshold};
        prev = prev_pattern;
        b = base_speed;
        g = inner_gain;
        lv = 10 * b;
        rv = 10 * b;
        case (cur_mode)
            MODE_BLANK:
            begin
                held_position = 4'sd0;
                cur_mode = intersection_mode(prev, pat);
            end
            MODE_WAIT_L:
                if (in_codes(pat, ENTER_CODES))
                    cur_mode = MODE_TURN_L;
            MODE_TURN_L:
            begin
                lv = 7 * (b - 3 * g);
                rv = 8 * (b + 768);
                if (in_codes(pat, LEFT_EXIT_CODES))
                    cur_mode = MODE_FOLLOW;
            end
            MODE_WAIT_R:
                if (in_codes(pat, ENTER_CODES))
                    cur_mode = MODE_TURN_R;
            MODE_TURN_R:
            begin
                lv = 8 * (b + 3 * g);
                rv = 7 * (b - 768);
                if (in_codes(pat, RIGHT_EXIT_CODES))
                    cur_mode = MODE_FOLLOW;
            end
            default:
            begin
                held_position = line_weight(pat, held_position);
                w = held_position;
                // Inner wheel is halved with round-half-up
                if (w > 0)
                begin
                    lv = 8 * (b + 128 * w);
                    rv = (7 * (2 * b - w * g) + 1) >>> 1;
                end
                else if (w < 0)
                begin
                    lv = (7 * (2 * b + w * g) + 1) >>> 1;
                    rv = 8 * (b - 128 * w);
                end
                cur_mode = intersection_mode(prev, pat);
            end
        endcase
        prev_pattern = pat;
        cmd.left_velocity  = clamp16(lv);
        cmd.right_velocity = clamp16(rv);
        cmd.next_mode      = cur_mode;
        cmd.line_position  = held_position;
        cmd.sensor_pattern = pat;
        pending_commands.push_back(cmd);
    endtask

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Build raw samples that threshold to the given pattern
    function automatic sensor_item_t scan_for(logic [7:0] pat);
        logic [7:0][SENSOR_W-1:0] samples;
        int thr;
        int r;
        thr = line_threshold;
        for (int k = 0; k < 8; k++)
        begin
            r = $urandom_range(0, 9);
            if (pat[k] && thr > 0)
                samples[k] = (r == 0) ? SENSOR_W'(thr - 1) : (r == 1) ? SENSOR_W'(0) :
                             SENSOR_W'($urandom_range(0, thr - 1));
            else
                samples[k] = (r == 0) ? SENSOR_W'(thr) : (r == 1) ? SENSOR_W'(4095) :
                             SENSOR_W'($urandom_range(thr, 4095));
        end
        return sensor_item_t'(samples);
    endfunction

    function automatic logic [7:0] follow_pattern();
        case ($urandom_range(0, 3))
            0: return 8'h01 << $urandom_range(0, 7);
            1: return 8'h03 << $urandom_range(0, 6);
            2: return 8'h18;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] maybe_broken(logic [7:0] pat);
        return ($urandom_range(0, 99) < 8) ? 8'($urandom) : pat;
    endfunction

    task automatic send_scan(input sensor_item_t scan);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            sensor_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sensors      <= scan;
        sensor_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (sensor_ready)
                break;
        end
        compute_wheel_command(scan);
        items_sent++;
    endtask

    task automatic send_pattern(input logic [7:0] pat);
        send_scan(scan_for(pat));
    endtask

    // First pattern sits at index n-1
    task automatic send_patterns(input logic [15:0][7:0] pats, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_pattern(pats[i]);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        sensor_valid <= 1'b0;
        while (pending_commands.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LINE_THRESHOLD: line_threshold = data;
            CFG_BASE_SPEED:     base_speed = data;
            CFG_INNER_GAIN:     inner_gain = data[9:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [11:0] thr, input logic [11:0] base,
                              input logic [11:0] gain);
        wait_idle();
        write_reg(CFG_LINE_THRESHOLD, thr);
        write_reg(CFG_BASE_SPEED, base);
        write_reg(CFG_INNER_GAIN, gain);
    endtask

    task automatic run_turn(input logic [7:0] approach_a, input logic [7:0] approach_b,
                            input logic [5:0][7:0] cur_codes, input logic [5:0][7:0] exit_codes);
        send_pattern(maybe_broken($urandom_range(0, 1) ? approach_a : approach_b));
        send_pattern(maybe_broken(pick_code(cur_codes)));
        repeat ($urandom_range(0, 3)) send_pattern(8'($urandom));
        send_pattern(maybe_broken(pick_code(ENTER_CODES)));
        repeat ($urandom_range(0, 3)) send_pattern(8'($urandom));
        send_pattern(maybe_broken(pick_code(exit_codes)));
    endtask

    task automatic run_random_traffic(input int n);
        int target;
        int r;
        target = items_sent + n;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                repeat ($urandom_range(1, 6)) send_pattern(follow_pattern());
            else if (r < 45)
                run_turn(8'hF0, 8'hF8, LEFT_CUR_CODES, LEFT_EXIT_CODES);
            else if (r < 60)
                run_turn(8'h0F, 8'h1F, RIGHT_CUR_CODES, RIGHT_EXIT_CODES);
            else if (r < 75)
            begin
                send_pattern(maybe_broken($urandom_range(0, 1) ? 8'h10 : 8'h08));
                send_pattern(maybe_broken(8'h00));
                repeat ($urandom_range(1, 3)) send_pattern(follow_pattern());
            end
            else if (r < 90)
                send_pattern(8'($urandom));
            else
                send_scan(sensor_item_t'({$urandom, $urandom, $urandom}));
        end
    endtask

    task automatic test_follow_weights();
        send_patterns({8'h00, 8'h80, 8'h01, 8'h40, 8'h02, 8'h20, 8'h04, 8'h10,
                       8'h08, 8'h18, 8'h81, 8'h00}, 12);
        send_scan('0);
        send_scan('1);
    endtask

    task automatic test_intersections();
        // blank, left turn, right turn, each back to follow
        send_patterns({8'h10, 8'h00, 8'h08, 8'hF8, 8'hD8, 8'h7E, 8'h55, 8'h30,
                       8'h0F, 8'h13, 8'hFF, 8'h04}, 12);
    endtask

    task automatic test_unused_index();
        wait_idle();
        write_reg(CFG_UNUSED_INDEX, 12'hFFF);
        send_patterns({8'h18, 8'h01, 8'hF0}, 3);
    endtask

    task automatic test_backpressure();
        wait_idle();
        idle_on = 1'b0;
        ready_hold_cycles = 200;
        repeat (30) send_pattern(follow_pattern());
        idle_on = 1'b1;
    endtask

    task automatic test_config_sweep();
        logic [11:0] thr;
        logic [11:0] base;
        logic [11:0] gain;
        int          n;
        for (int phase = 0; phase < 9; phase++)
        begin
            n = 120;
            thr = 12'($urandom_range(1, 4095));
            base = 12'($urandom_range(0, 4095));
            gain = 12'($urandom_range(0, 4095));
            case (phase)
                0:
                begin
                    thr = LINE_THRESHOLD_RESET;
                    base = BASE_SPEED_RESET;
                    gain = 12'(INNER_GAIN_RESET);
                    n = 90;
                end
                1:
                begin
                    thr = 12'd2048;
                    base = 12'd0;
                    gain = 12'd0;
                end
                2:
                begin
                    thr = 12'd4095;
                    base = 12'd4095;
                    gain = 12'hFFF;
                end
                3:
                begin
                    thr = 12'd1;
                    base = 12'd2048;
                    gain = 12'd512;
                    n = 60;
                end
                // nothing can read as line
                4:
                begin
                    thr = 12'd0;
                    n = 20;
                end
                5:
                begin
                    thr = 12'd3000;
                    base = 12'd768;
                    gain = 12'd256;
                end
                default: ;
            endcase
            set_config(thr, base, gain);
            idle_on = (phase % 3) != 2;
            run_random_traffic(n);
        end
        idle_on = 1'b1;
    endtask

    // Result receiver: random stalls plus a requested long hold-off
    initial
    begin
        int stall;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold_cycles > 0)
            begin
                stall = ready_hold_cycles;
                ready_hold_cycles = 0;
            end
            else
                stall = pick_gap();
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_commands.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result item: L=%0d R=%0d mode=%0d pos=%0d pat=%02h",
                             result.left_velocity, result.right_velocity, result.next_mode,
                             result.line_position, result.sensor_pattern);
            end
            else
            begin
                expected_cmd = pending_commands.pop_front();
                if (result.left_velocity !== expected_cmd.left_velocity ||
                    result.right_velocity !== expected_cmd.right_velocity ||
                    result.next_mode !== expected_cmd.next_mode ||
                    result.line_position !== expected_cmd.line_position ||
                    result.sensor_pattern !== expected_cmd.sensor_pattern)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"mismatch: expected L=%0d R=%0d mode=%0d pos=%0d pat=%02h,",
                                  " got L=%0d R=%0d mode=%0d pos=%0d pat=%02h"},
                                 expected_cmd.left_velocity, expected_cmd.right_velocity,
                                 expected_cmd.next_mode, expected_cmd.line_position,
                                 expected_cmd.sensor_pattern, result.left_velocity,
                                 result.right_velocity, result.next_mode,
                                 result.line_position, result.sensor_pattern);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_follow_weights();
        test_intersections();
        test_unused_index();
        test_backpressure();
        test_config_sweep();
        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_line_follower_intersection_controller passed");
        else
            $display("tb_line_follower_intersection_controller failed");
        $finish;
    end

endmodule
